/* rtl/vps_pkg.sv */
// Shared types, constants and helpers for the vacuum pick/release sequencer.
package vps_pkg;

  // Vacuum heads; each head has a pick and a release sequencer.
  localparam int HEADS     = 2;
  localparam int MAX_TRIES = 2;
  localparam int NSEQ      = 2 * HEADS;
  localparam int SEQ_W     = (NSEQ > 1) ? $clog2(NSEQ) : 1;

  // Decoupling queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int TIME_W  = 16;
  localparam int DELAY_W = 17;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  // Configuration register indexes.
  localparam logic [2:0] REG_DOWN    = 3'd0;
  localparam logic [2:0] REG_UP      = 3'd1;
  localparam logic [2:0] REG_SWITCH  = 3'd2;
  localparam logic [2:0] REG_SUCTION = 3'd3;
  localparam logic [2:0] REG_BLOWOFF = 3'd4;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DOWN  = 3'd1;
  localparam logic [2:0] PH_OFF   = 3'd2;
  localparam logic [2:0] PH_AIR   = 3'd3;
  localparam logic [2:0] PH_UP    = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;
  localparam logic [2:0] PH_OK    = 3'd6;
  localparam logic [2:0] PH_NG    = 3'd7;

  // Outcomes.
  localparam logic [1:0] OC_NONE = 2'd0;
  localparam logic [1:0] OC_RUN  = 2'd1;
  localparam logic [1:0] OC_OK   = 2'd2;
  localparam logic [1:0] OC_NG   = 2'd3;

  // Request kinds decided by the front.
  localparam logic [1:0] KIND_STEP   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_IGNORE = 2'd2;

  // Operations.
  localparam logic OP_PICK = 1'b0;

  typedef logic [SEQ_W-1:0] seq_idx_t;

  typedef struct packed {
    logic req_type;
    logic head;
    logic operation;
    logic part_held;
  } in_item_t;

  typedef struct packed {
    logic       out_head;
    logic       out_operation;
    logic       lower_cmd;
    logic       raise_cmd;
    logic       suction_on_cmd;
    logic       valves_off_cmd;
    logic [2:0] phase;
    logic [1:0] outcome;
    logic [1:0] tries_used;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       head;
    logic       operation;
    logic       part_held;
    seq_idx_t   idx;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // base * (retry + 1), saturated to the delay counter width.
  function automatic logic [DELAY_W-1:0] scaled_delay(input logic [TIME_W-1:0] base,
                                                      input logic [1:0] retry);
    logic [TIME_W+2:0] t;
    t = (TIME_W+3)'(base) * (TIME_W+3)'(retry) + (TIME_W+3)'(base);
    if (t > (TIME_W+3)'(DELAY_MAX)) begin
      scaled_delay = DELAY_MAX;
    end else begin
      scaled_delay = t[DELAY_W-1:0];
    end
  endfunction

endpackage

/* rtl/vps_front.sv */
// Front end: input handshake and classification of requests into queue entries.
module vps_front import vps_pkg::*; (
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  q_status_t q_st,
  output logic      push,
  output q_entry_t  push_entry
);

  logic head_bad;

  assign head_bad = (32'(in_data.head) >= HEADS);

  assign in_stall = q_st.full;
  assign push     = in_valid && !q_st.full;

  always_comb begin
    push_entry.head      = in_data.head;
    push_entry.operation = in_data.operation;
    push_entry.part_held = in_data.part_held;
    push_entry.idx       = seq_idx_t'({in_data.head, in_data.operation});
    if (head_bad) begin
      push_entry.kind = KIND_IGNORE;
    end else if (in_data.req_type) begin
      push_entry.kind = KIND_START;
    end else begin
      push_entry.kind = KIND_STEP;
    end
  end

endmodule

/* rtl/vps_queue.sv */
// Short FIFO between the front and the back.
module vps_queue import vps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  pop_entry,
  output q_status_t q_st
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (32'(p) == QDEPTH - 1) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + QPTR_W'(1);
    end
  endfunction

  assign q_st.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_st.empty = (count_r == '0);
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/vps_back.sv */
// Back end: timing registers, per-sequencer state update and result register.
module vps_back import vps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [TIME_W-1:0] cfg_wdata,
  input  logic             q_valid,
  input  q_entry_t         q_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  logic [TIME_W-1:0] down_time_r, up_time_r, switch_time_r;
  logic [TIME_W-1:0] suction_time_r, blowoff_time_r;

  logic [2:0]         phase_r   [NSEQ];
  logic [1:0]         retry_r   [NSEQ];
  logic [DELAY_W-1:0] delay_r   [NSEQ];
  logic [1:0]         outcome_r [NSEQ];

  logic               out_valid_r;
  out_item_t          out_data_r, res_nxt;

  logic [2:0]         ph_cur, ph_nxt;
  logic [1:0]         rt_cur, rt_nxt;
  logic [DELAY_W-1:0] dl_cur, dl_set, dl_nxt;
  logic [1:0]         oc_cur, oc_nxt;
  logic               lower, raise, suck, voff;
  logic               go, upd;

  assign go        = q_valid && (!out_valid_r || !out_stall);
  assign pop       = go;
  assign upd       = go && (q_entry.kind != KIND_IGNORE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ph_cur = phase_r[q_entry.idx];
  assign rt_cur = retry_r[q_entry.idx];
  assign dl_cur = delay_r[q_entry.idx];
  assign oc_cur = outcome_r[q_entry.idx];

  always_comb begin
    ph_nxt = ph_cur;
    rt_nxt = rt_cur;
    dl_set = dl_cur;
    oc_nxt = oc_cur;
    lower  = 1'b0;
    raise  = 1'b0;
    suck   = 1'b0;
    voff   = 1'b0;
    case (ph_cur)
      PH_IDLE: rt_nxt = '0;
      PH_DOWN: begin
        lower  = 1'b1;
        dl_set = scaled_delay(down_time_r, rt_cur);
        ph_nxt = PH_OFF;
      end
      PH_OFF: begin
        if (dl_cur == '0) begin
          voff   = 1'b1;
          dl_set = DELAY_W'(switch_time_r);
          ph_nxt = PH_AIR;
        end
      end
      PH_AIR: begin
        if (dl_cur == '0) begin
          if (q_entry.operation == OP_PICK) begin
            suck   = 1'b1;
            dl_set = DELAY_W'(suction_time_r);
          end else begin
            dl_set = DELAY_W'(blowoff_time_r);
          end
          ph_nxt = PH_UP;
        end
      end
      PH_UP: begin
        if (dl_cur == '0) begin
          raise  = 1'b1;
          dl_set = scaled_delay(up_time_r, rt_cur);
          ph_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (dl_cur == '0) begin
          if ((q_entry.operation == OP_PICK) == q_entry.part_held) begin
            ph_nxt = PH_OK;
          end else begin
            rt_nxt = rt_cur + 2'd1;
            ph_nxt = (32'(rt_nxt) < MAX_TRIES) ? PH_DOWN : PH_NG;
          end
        end
      end
      PH_OK: begin
        oc_nxt = OC_OK;
        ph_nxt = PH_IDLE;
      end
      default: begin
        oc_nxt = OC_NG;
        ph_nxt = PH_IDLE;
      end
    endcase
    dl_nxt = (dl_set != '0) ? dl_set - DELAY_W'(1) : dl_set;

    // Start overrides the step path.
    if (q_entry.kind == KIND_START) begin
      ph_nxt = PH_DOWN;
      rt_nxt = '0;
      dl_nxt = '0;
      oc_nxt = OC_RUN;
      lower  = 1'b0;
      raise  = 1'b0;
      suck   = 1'b0;
      voff   = 1'b0;
    end

    res_nxt.out_head      = q_entry.head;
    res_nxt.out_operation = q_entry.operation;
    if (q_entry.kind == KIND_IGNORE) begin
      res_nxt.lower_cmd      = 1'b0;
      res_nxt.raise_cmd      = 1'b0;
      res_nxt.suction_on_cmd = 1'b0;
      res_nxt.valves_off_cmd = 1'b0;
      res_nxt.phase          = PH_IDLE;
      res_nxt.outcome        = OC_NONE;
      res_nxt.tries_used     = '0;
    end else begin
      res_nxt.lower_cmd      = lower;
      res_nxt.raise_cmd      = raise;
      res_nxt.suction_on_cmd = suck;
      res_nxt.valves_off_cmd = voff;
      res_nxt.phase          = ph_nxt;
      res_nxt.outcome        = oc_nxt;
      res_nxt.tries_used     = rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_time_r    <= TIME_W'(300);
      up_time_r      <= TIME_W'(300);
      switch_time_r  <= TIME_W'(50);
      suction_time_r <= TIME_W'(100);
      blowoff_time_r <= TIME_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOWN:    down_time_r    <= cfg_wdata;
        REG_UP:      up_time_r      <= cfg_wdata;
        REG_SWITCH:  switch_time_r  <= cfg_wdata;
        REG_SUCTION: suction_time_r <= cfg_wdata;
        REG_BLOWOFF: blowoff_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSEQ; i++) begin
        phase_r[i]   <= PH_IDLE;
        retry_r[i]   <= '0;
        delay_r[i]   <= '0;
        outcome_r[i] <= OC_NONE;
      end
    end else if (upd) begin
      phase_r[q_entry.idx]   <= ph_nxt;
      retry_r[q_entry.idx]   <= rt_nxt;
      delay_r[q_entry.idx]   <= dl_nxt;
      outcome_r[q_entry.idx] <= oc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

/* rtl/vacuum_pick_release_sequencer_top.sv */
// Top level of the vacuum pick/release sequencer: front, queue and back.
//
//  channel  | ports                           | transfer when
//  ---------+---------------------------------+-------------------------
//  input    | in_valid, in_stall, in_data     | in_valid && !in_stall
//  result   | out_valid, out_stall, out_data  | out_valid && !out_stall
//  config   | cfg_we, cfg_index, cfg_wdata    | cfg_we
//
// One item per cycle sustained while out_stall stays low; after its input
// transfer an item is registered in the queue and then in the result register.
// The per-sequencer read-modify-write in the back sets that rate.
// Reset (synchronous, rst_n low) empties the queue, drops out_valid, puts
// every sequencer in idle with no outcome and reloads the default timings.
// A stalled result holds; the two-entry queue keeps in_stall a pure
// register decode, so the input side sees stall only when the queue is full.
module vacuum_pick_release_sequencer_top import vps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [TIME_W-1:0] cfg_wdata
);

  q_status_t q_st;
  q_entry_t  push_entry, pop_entry;
  logic      push, pop;

  // Front: handshake and request classification (start, step, bad head).
  vps_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_st       (q_st),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: lets the input keep flowing while a result waits.
  vps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_st       (q_st)
  );

  // Back: sequencer state, timers and the registered result.
  vps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (!q_st.empty),
    .q_entry   (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue can't be both full and empty.
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_st.full && q_st.empty))
    else $error("queue status inconsistent");

  // A transfer into an idle pipe shows up as a result after the queue and the result register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_st.empty && !out_valid) |=> ##1 out_valid)
    else $error("result missing after input transfer");

  // A never-started sequencer reports idle with no retries.
  a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.outcome == OC_NONE) |->
      (out_data.phase == PH_IDLE && out_data.tries_used == 2'd0))
    else $error("never-started sequencer not idle");

endmodule
